[hw/rtl/lpht_pkg.sv]
`default_nettype none
package lpht_pkg;
    localparam int Buckets = 256;
    localparam int IdxW = $clog2(Buckets);
    localparam int CntW = IdxW + 1;
    localparam int KeyBytes = 8;
    localparam int KeyW = 8 * KeyBytes;
    localparam int LenW = 4;
    localparam int ValW = 32;
    localparam int HashW = 64;
    localparam logic [HashW-1:0] HashSeed = 64'h100;
    localparam logic [HashW-1:0] HashMul = 64'd1111111111111111111;
    localparam logic [CntW+1:0] LoadLimit = (CntW + 2)'(3 * Buckets);

    localparam logic [1:0] ActInsert = 2'd0;
    localparam logic [1:0] ActLookup = 2'd1;
    localparam logic [1:0] ActDelete = 2'd2;

    localparam logic [2:0] StInserted = 3'd0;
    localparam logic [2:0] StUpdated = 3'd1;
    localparam logic [2:0] StFound = 3'd2;
    localparam logic [2:0] StNotFound = 3'd3;
    localparam logic [2:0] StDeleted = 3'd4;
    localparam logic [2:0] StFull = 3'd5;

    localparam logic [1:0] MarkEmpty = 2'd0;
    localparam logic [1:0] MarkUsed = 2'd1;
    localparam logic [1:0] MarkTomb = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic clear;      // clear one bucket mark
        logic load;       // capture request
        logic hash_step;  // one multiply phase of hash
        logic probe_init; // index <- home bucket
        logic rd;         // read bucket at index
        logic advance;    // note tomb, index++
        logic wr_upd;     // write value at index
        logic wr_ins;     // write entry at index or tomb
        logic wr_del;     // tombstone at index
        logic out_load;   // capture result
        logic [2:0] status;
    } lpht_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clear_last;
        logic hash_done;
        logic [1:0] action;
        logic full;
        logic live_zero;
        logic [1:0] mark;
        logic match;
        logic have_tomb;
        logic last_probe;
    } lpht_sts_t;
endpackage
`default_nettype wire

[hw/rtl/lpht_datapath.sv]
`default_nettype none
module lpht_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire lpht_pkg::lpht_cmd_t   cmd,
    output lpht_pkg::lpht_sts_t        sts,
    input  wire logic [1:0]            action,
    input  wire logic [lpht_pkg::KeyW-1:0] key,
    input  wire logic [lpht_pkg::LenW-1:0] key_length,
    input  wire logic [lpht_pkg::ValW-1:0] value,
    output logic [2:0]                 status,
    output logic [lpht_pkg::ValW-1:0]  value_out,
    output logic [lpht_pkg::CntW-1:0]  entry_count
);
    localparam int IW = lpht_pkg::IdxW;
    localparam int CW = lpht_pkg::CntW;
    // entry word: key, length, hash, value
    localparam int EW = lpht_pkg::KeyW + lpht_pkg::LenW + lpht_pkg::HashW + lpht_pkg::ValW;
    localparam logic [31:0] MulLo = lpht_pkg::HashMul[31:0];
    localparam logic [31:0] MulHi = lpht_pkg::HashMul[63:32];

    logic [1:0] act_reg;
    logic [lpht_pkg::KeyW-1:0] key_reg;
    logic [lpht_pkg::LenW-1:0] len_reg;
    logic [lpht_pkg::ValW-1:0] val_reg;
    logic [lpht_pkg::HashW-1:0] hash_reg;
    logic [lpht_pkg::HashW-1:0] acc_reg;
    logic [1:0] mul_ph_reg;
    logic [lpht_pkg::LenW-1:0] byte_reg;
    logic [IW-1:0] idx_reg;
    logic [CW-1:0] nprobe_reg;
    logic [IW-1:0] tomb_reg;
    logic tomb_v_reg;
    logic [CW-1:0] live_reg;
    logic [CW-1:0] tombs_reg;
    logic [IW-1:0] clr_idx_reg;
    logic [1:0] mark_mem [lpht_pkg::Buckets];
    logic [EW-1:0] mem [lpht_pkg::Buckets];
    logic [EW-1:0] rd_reg;
    logic [1:0] mark_reg;

    logic [lpht_pkg::LenW-1:0] len_c;
    logic [lpht_pkg::KeyW-1:0] kmask;
    logic [lpht_pkg::KeyW-1:0] key_shift;
    logic [7:0] cur_byte;
    logic [IW-1:0] wr_idx;
    logic use_tomb;
    logic [CW-1:0] live_next;
    logic [CW-1:0] tombs_next;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [CW:0] load_sum;

    always_comb
    begin
        len_c = (key_length > lpht_pkg::LenW'(lpht_pkg::KeyBytes))
              ? lpht_pkg::LenW'(lpht_pkg::KeyBytes) : key_length;
        kmask = '0;
        for (int i = 0; i < lpht_pkg::KeyBytes; i++)
        begin
            if (i < int'(len_c))
                kmask[8*i +: 8] = 8'hFF;
        end
        key_shift = key_reg >> {byte_reg, 3'b000};
        cur_byte = key_shift[7:0];
        wr_idx = tomb_v_reg ? tomb_reg : idx_reg;
        // insert at the bucket being checked when it is itself the first tombstone
        use_tomb = tomb_v_reg || (mark_reg == lpht_pkg::MarkTomb);
    end

    // one 32x32 multiplier, three phases per key byte:
    // lo*lo, then lo*hi and hi*lo folded into the upper word
    always_comb
    begin
        case (mul_ph_reg)
            2'd0:
            begin
                mul_a = hash_reg[31:0] ^ {24'd0, cur_byte};
                mul_b = MulLo;
            end
            2'd1:
            begin
                mul_a = hash_reg[31:0];
                mul_b = MulHi;
            end
            default:
            begin
                mul_a = hash_reg[63:32];
                mul_b = MulLo;
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb
    begin
        live_next = live_reg;
        tombs_next = tombs_reg;
        if (cmd.wr_ins)
        begin
            live_next = live_reg + 1'b1;
            if (use_tomb)
                tombs_next = tombs_reg - 1'b1;
        end
        else if (cmd.wr_del)
        begin
            live_next = live_reg - 1'b1;
            tombs_next = tombs_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            tombs_reg <= '0;
            byte_reg <= '0;
            mul_ph_reg <= '0;
            clr_idx_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
                clr_idx_reg <= clr_idx_reg + 1'b1;
            if (cmd.load)
            begin
                byte_reg <= '0;
                mul_ph_reg <= '0;
            end
            else if (cmd.hash_step)
            begin
                if (mul_ph_reg == 2'd2)
                begin
                    mul_ph_reg <= '0;
                    byte_reg <= byte_reg + 1'b1;
                end
                else
                    mul_ph_reg <= mul_ph_reg + 1'b1;
            end
            live_reg <= live_next;
            tombs_reg <= tombs_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            key_reg <= key & kmask;
            len_reg <= len_c;
            val_reg <= value;
            hash_reg <= lpht_pkg::HashSeed;
        end
        else if (cmd.hash_step)
        begin
            case (mul_ph_reg)
                2'd0:
                begin
                    hash_reg <= {hash_reg[63:32], mul_a};
                    acc_reg <= mul_p;
                end
                2'd1:
                    acc_reg[63:32] <= acc_reg[63:32] + mul_p[31:0];
                default:
                    hash_reg <= {acc_reg[63:32] + mul_p[31:0], acc_reg[31:0]};
            endcase
        end
        if (cmd.probe_init)
        begin
            idx_reg <= hash_reg[IW-1:0];
            nprobe_reg <= '0;
            tomb_v_reg <= 1'b0;
        end
        else if (cmd.advance)
        begin
            if (mark_reg == lpht_pkg::MarkTomb && !tomb_v_reg)
            begin
                tomb_v_reg <= 1'b1;
                tomb_reg <= idx_reg;
            end
            idx_reg <= idx_reg + 1'b1;
            nprobe_reg <= nprobe_reg + 1'b1;
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[idx_reg];
            mark_reg <= mark_mem[idx_reg];
        end
        if (cmd.clear)
            mark_mem[clr_idx_reg] <= lpht_pkg::MarkEmpty;
        else if (cmd.wr_ins)
            mark_mem[wr_idx] <= lpht_pkg::MarkUsed;
        else if (cmd.wr_del)
            mark_mem[idx_reg] <= lpht_pkg::MarkTomb;
        if (cmd.wr_ins)
            mem[wr_idx] <= {key_reg, len_reg, hash_reg, val_reg};
        else if (cmd.wr_upd)
            mem[idx_reg] <= {rd_reg[EW-1:lpht_pkg::ValW], val_reg};
        if (cmd.out_load)
        begin
            status <= cmd.status;
            value_out <= (cmd.status == lpht_pkg::StFound) ? rd_reg[lpht_pkg::ValW-1:0] : '0;
            entry_count <= live_next;
        end
    end

    always_comb
    begin
        load_sum = {1'b0, live_reg} + {1'b0, tombs_reg};
        sts.clear_last = (clr_idx_reg == '1);
        sts.hash_done = (byte_reg == len_reg) && (mul_ph_reg == 2'd0);
        sts.action = act_reg;
        sts.full = ({1'b0, load_sum, 2'b00} >= {2'b00, lpht_pkg::LoadLimit});
        sts.live_zero = (live_reg == '0);
        sts.mark = mark_reg;
        sts.match = (mark_reg == lpht_pkg::MarkUsed)
                  && (rd_reg[EW-1:lpht_pkg::ValW] == {key_reg, len_reg, hash_reg});
        sts.have_tomb = tomb_v_reg;
        sts.last_probe = (nprobe_reg == CW'(lpht_pkg::Buckets - 1));
    end
endmodule
`default_nettype wire

[hw/rtl/lpht_ctrl.sv]
`default_nettype none
module lpht_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output lpht_pkg::lpht_cmd_t      cmd,
    input  wire lpht_pkg::lpht_sts_t sts
);
    typedef enum logic [2:0] {IDLE, HASH, DECIDE, READ, CHECK, OUT, CLEAR} state_t;
    state_t state_reg, state_next;
    logic out_v_reg, out_v_next;

    assign out_valid = out_v_reg;
    assign in_ready = (state_reg == IDLE) && !out_v_reg;

    always_comb
    begin
        state_next = state_reg;
        out_v_next = out_v_reg;
        cmd = '0;
        cmd.status = lpht_pkg::StNotFound;
        if (out_v_reg && out_ready)
            out_v_next = 1'b0;
        case (state_reg)
            CLEAR:
            begin
                cmd.clear = 1'b1;
                if (sts.clear_last)
                    state_next = IDLE;
            end
            IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = HASH;
                end
            end
            HASH:
            begin
                if (sts.hash_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next = DECIDE;
                end
                else
                    cmd.hash_step = 1'b1;
            end
            DECIDE:
            begin
                if (sts.action == lpht_pkg::ActInsert && sts.full)
                begin
                    cmd.status = lpht_pkg::StFull;
                    cmd.out_load = 1'b1;
                    state_next = OUT;
                end
                else if (sts.action == lpht_pkg::ActInsert
                         || ((sts.action == lpht_pkg::ActLookup
                              || sts.action == lpht_pkg::ActDelete) && !sts.live_zero))
                begin
                    cmd.rd = 1'b1;
                    state_next = CHECK;
                end
                else
                begin
                    cmd.out_load = 1'b1;
                    state_next = OUT;
                end
            end
            READ:
            begin
                cmd.rd = 1'b1;
                state_next = CHECK;
            end
            CHECK:
            begin
                state_next = OUT;
                if (sts.action == lpht_pkg::ActInsert)
                begin
                    if (sts.mark == lpht_pkg::MarkEmpty)
                    begin
                        cmd.wr_ins = 1'b1;
                        cmd.status = lpht_pkg::StInserted;
                        cmd.out_load = 1'b1;
                    end
                    else if (sts.match)
                    begin
                        cmd.wr_upd = 1'b1;
                        cmd.status = lpht_pkg::StUpdated;
                        cmd.out_load = 1'b1;
                    end
                    else if (sts.last_probe)
                    begin
                        // no empty bucket anywhere: use the tombstone if one was seen
                        if (sts.have_tomb || sts.mark == lpht_pkg::MarkTomb)
                        begin
                            cmd.wr_ins = 1'b1;
                            cmd.status = lpht_pkg::StInserted;
                            cmd.out_load = 1'b1;
                        end
                        else
                        begin
                            cmd.status = lpht_pkg::StFull;
                            cmd.out_load = 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next = READ;
                    end
                end
                else
                begin
                    if (sts.mark == lpht_pkg::MarkEmpty)
                        cmd.out_load = 1'b1;
                    else if (sts.match)
                    begin
                        cmd.status = (sts.action == lpht_pkg::ActLookup)
                                   ? lpht_pkg::StFound : lpht_pkg::StDeleted;
                        cmd.wr_del = (sts.action == lpht_pkg::ActDelete);
                        cmd.out_load = 1'b1;
                    end
                    else if (sts.last_probe)
                        cmd.out_load = 1'b1;
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next = READ;
                    end
                end
            end
            OUT:
            begin
                out_v_next = 1'b1;
                state_next = IDLE;
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CLEAR;
            out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_v_reg <= out_v_next;
        end
    end
endmodule
`default_nettype wire

[hw/rtl/linear_probe_hash_table.sv]
`default_nettype none
// Linear-probing hash table of 256 buckets. Each input item inserts/updates,
// looks up or deletes one key of up to 8 bytes; one result item comes back
// with status, looked-up value and live entry count. After reset the bucket
// marks are cleared one per cycle with s_axis_tready low.
// Per item: three multiply phases per key byte for the 64-bit multiplicative
// hash on a shared 32x32 multiplier, a step that sets the home bucket, a
// decide step (reads the home bucket), then one compare step per bucket
// probed with a read step between probes, and an output step to present
// the result. No bucket is probed for a refused insert, an unused action or
// a lookup or delete on an empty table. Items are handled one at a time; the
// next item is taken the cycle after the previous result has been taken.
// Inserts are refused (status full) once live plus tombstone entries reach
// 3/4 of the table.
module linear_probe_hash_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // action[1:0], key[65:2], key_length[69:66], value[101:70], zero fill
    input  wire logic [103:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[2:0], value_out[34:3], entry_count[43:35], zero fill
    output logic [47:0]      m_axis_tdata
);
    lpht_pkg::lpht_cmd_t cmd;
    lpht_pkg::lpht_sts_t sts;
    logic [2:0] status;
    logic [lpht_pkg::ValW-1:0] value_out;
    logic [lpht_pkg::CntW-1:0] entry_count;

    lpht_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .sts(sts)
    );

    lpht_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .action(s_axis_tdata[1:0]), .key(s_axis_tdata[65:2]),
        .key_length(s_axis_tdata[69:66]), .value(s_axis_tdata[101:70]),
        .status(status), .value_out(value_out), .entry_count(entry_count)
    );

    assign m_axis_tdata = {4'd0, entry_count, value_out, status};
endmodule
`default_nettype wire
